[rtl/bcmr_pkg.sv]
package bcmr_pkg;

   localparam int MaxPe   = 16;
   localparam int PeBits  = 4;
   localparam int AddrW   = 2 * PeBits;
   localparam int Depth   = MaxPe * MaxPe;
   localparam int WordW   = 32;

   typedef struct packed {
      logic [PeBits-1:0] source_pe;
      logic              is_barrier;
      logic [WordW-1:0]  dest_id;
      logic [WordW-1:0]  sender_id;
      logic              round_parity;
   } bcmr_req_type;

   typedef struct packed {
      logic [PeBits-1:0] out_dest_pe;
      logic              out_barrier;
      logic [WordW-1:0]  out_id_or_count;
      logic [WordW-1:0]  out_sender;
      logic              out_round_parity;
      logic              via_link;
      logic [1:0]        link_index;
      logic              last;
   } bcmr_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ORD_EMIT,
      ST_BAR_EMIT
   } bcmr_state_type;

   typedef struct packed {
      logic capture;
      logic emit_ord;
      logic emit_bar;
   } bcmr_cmd_type;

   typedef struct packed {
      logic req_ok;
      logic req_barrier;
      logic out_free;
      logic last_copy;
   } bcmr_stat_type;

endpackage

[rtl/bcmr_ctrl.sv]
module bcmr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bcmr_pkg::bcmr_stat_type stat,
   output bcmr_pkg::bcmr_cmd_type  cmd
);
   import bcmr_pkg::*;

   bcmr_state_type state_ff;
   bcmr_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            // an out-of-range request is taken and dropped here
            if (req_valid && stat.req_ok) begin
               cmd.capture = 1'b1;
               state_in    = stat.req_barrier ? ST_BAR_EMIT : ST_ORD_EMIT;
            end
         end
         ST_ORD_EMIT: begin
            if (stat.out_free) begin
               cmd.emit_ord = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_BAR_EMIT: begin
            if (stat.out_free) begin
               cmd.emit_bar = 1'b1;
               if (stat.last_copy) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/bcmr_datapath.sv]
module bcmr_datapath #(
   parameter int NUM_ELEMENTS  = 16,
   parameter int NUM_DEVICES   = 4,
   parameter int ELEMENT_SHIFT = 28
) (
   input  logic                    clock,
   input  logic                    reset,
   input  bcmr_pkg::bcmr_req_type  req_data,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output bcmr_pkg::bcmr_rsp_type  rsp_data,
   input  bcmr_pkg::bcmr_cmd_type  cmd,
   output bcmr_pkg::bcmr_stat_type stat
);
   import bcmr_pkg::*;

   localparam int PeCount  = (NUM_ELEMENTS > MaxPe) ? MaxPe : NUM_ELEMENTS;
   localparam int DevCount = (NUM_DEVICES < 1) ? 1 : NUM_DEVICES;
   localparam logic [PeBits:0]   PeCountV = (PeBits+1)'(PeCount);
   localparam logic [PeBits-1:0] PeLast   = PeBits'(PeCount - 1);

   // element index modulo device count, as a constant table
   logic [PeBits-1:0] mod_rom [MaxPe];
   for (genvar g = 0; g < MaxPe; g++) begin : g_mod
      assign mod_rom[g] = PeBits'(g % DevCount);
   end

   logic [WordW-1:0]  mem [Depth];
   logic              valid_ff [Depth];

   logic [PeBits-1:0] src_ff;
   logic [PeBits-1:0] dst_ff;
   logic [WordW-1:0]  dest_id_ff;
   logic [WordW-1:0]  sender_ff;
   logic              parity_ff;
   logic [PeBits-1:0] j_ff;
   logic [PeBits-1:0] j_in;
   logic [WordW-1:0]  rd_data_ff;
   logic              rd_valid_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   bcmr_rsp_type      rsp_data_ff;
   bcmr_rsp_type      rsp_data_in;

   logic [WordW-1:0]  shifted;
   logic [PeBits-1:0] req_dst;
   logic              src_ok;
   logic              dst_ok;
   logic              rd_en;
   logic [AddrW-1:0]  rd_addr;
   logic [AddrW-1:0]  wr_addr;
   logic [AddrW-1:0]  clr_addr;
   logic [WordW-1:0]  cnt;
   logic [WordW-1:0]  cnt_inc;
   logic [PeBits-1:0] dst_sel;
   logic              link;
   logic              last_copy;

   always_comb begin
      shifted   = req_data.dest_id >> ELEMENT_SHIFT;
      req_dst   = shifted[PeBits-1:0];
      src_ok    = {1'b0, req_data.source_pe} < PeCountV;
      dst_ok    = shifted < WordW'(PeCount);
      last_copy = (j_ff == PeLast);

      stat.req_ok      = src_ok && (req_data.is_barrier || dst_ok);
      stat.req_barrier = req_data.is_barrier;
      stat.out_free    = !rsp_valid_ff || rsp_ready;
      stat.last_copy   = last_copy;

      // barrier reads run one entry ahead of the copy being emitted
      rd_en   = cmd.capture || cmd.emit_bar;
      rd_addr = cmd.capture ?
                {req_data.source_pe, (req_data.is_barrier ? {PeBits{1'b0}} : req_dst)} :
                {src_ff, j_ff + 1'b1};
      wr_addr  = {src_ff, dst_ff};
      clr_addr = {src_ff, j_ff};

      cnt     = rd_valid_ff ? rd_data_ff : '0;
      cnt_inc = (&cnt) ? cnt : cnt + 1'b1;

      j_in = j_ff;
      if (cmd.capture) begin
         j_in = '0;
      end else if (cmd.emit_bar) begin
         j_in = j_ff + 1'b1;
      end

      dst_sel = cmd.emit_bar ? j_ff : dst_ff;
      link    = mod_rom[src_ff] != mod_rom[dst_sel];

      rsp_data_in.out_dest_pe      = dst_sel;
      rsp_data_in.out_barrier      = cmd.emit_bar;
      rsp_data_in.out_id_or_count  = cmd.emit_bar ? cnt : dest_id_ff;
      rsp_data_in.out_sender       = cmd.emit_bar ?
                                     (WordW'(src_ff) << ELEMENT_SHIFT) : sender_ff;
      rsp_data_in.out_round_parity = parity_ff;
      rsp_data_in.via_link         = link;
      rsp_data_in.link_index       = link ? mod_rom[dst_sel][1:0] : 2'b00;
      rsp_data_in.last             = cmd.emit_bar ? last_copy : 1'b1;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.emit_ord || cmd.emit_bar) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
      if (cmd.emit_ord) begin
         mem[wr_addr] <= cnt_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Depth; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (cmd.emit_ord) begin
         valid_ff[wr_addr] <= 1'b1;
      end else if (cmd.emit_bar) begin
         valid_ff[clr_addr] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         src_ff     <= req_data.source_pe;
         dst_ff     <= req_dst;
         dest_id_ff <= req_data.dest_id;
         sender_ff  <= req_data.sender_id;
         parity_ff  <= req_data.round_parity;
      end
      if (cmd.emit_ord || cmd.emit_bar) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/barrier_counting_message_router.sv]
// Ordinary request: held in the emit state until the output register is free, and no
// new request is taken meanwhile. Barrier: one copy per cycle while the output
// register is free. A request with an out-of-range source, or an ordinary one with an
// out-of-range destination, is taken and dropped. The rate is set by the single
// read/write port of the 256-entry pair counter memory. Synchronous active-high reset
// clears the state machine, output valid and all counter valid bits: no clearing pass.
module barrier_counting_message_router #(
   parameter int NUM_ELEMENTS  = 16,
   parameter int NUM_DEVICES   = 4,
   parameter int ELEMENT_SHIFT = 28
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bcmr_pkg::bcmr_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bcmr_pkg::bcmr_rsp_type rsp_data
);
   import bcmr_pkg::*;

   // command from the controller, status back from the datapath
   bcmr_cmd_type  cmd;
   bcmr_stat_type stat;

   // sequence request capture, the counter update and the barrier fan-out
   bcmr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // hold the request, the pair counters and the output register
   bcmr_datapath #(
      .NUM_ELEMENTS  (NUM_ELEMENTS),
      .NUM_DEVICES   (NUM_DEVICES),
      .ELEMENT_SHIFT (ELEMENT_SHIFT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import bcmr_pkg::*;

   // Match the block's defaults; the prediction follows these values.
   localparam int NUM_ELEMENTS  = 16;
   localparam int NUM_DEVICES   = 4;
   localparam int ELEMENT_SHIFT = 28;

   localparam int PE_COUNT  = (NUM_ELEMENTS > MaxPe) ? MaxPe : NUM_ELEMENTS;
   localparam int DEV_COUNT = (NUM_DEVICES < 1) ? 1 : NUM_DEVICES;

   localparam int RANDOM_REQS  = 330;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int MAX_PRINTED  = 100;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   bcmr_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   bcmr_rsp_type rsp_data;

   // Requests waiting to be driven, and the messages the router still owes.
   bcmr_req_type pending_reqs[$];
   bcmr_rsp_type expected_msgs[$];

   // Own copy of the per (source, destination) sent counters.
   bit [31:0] pair_count[MaxPe * MaxPe];

   int sent_count     = 0;
   int total_reqs     = 0;
   int error_count    = 0;
   int cycle_count    = 0;
   int send_idle_pct  = 14;
   int recv_stall_pct = 80;

   barrier_counting_message_router #(
      .NUM_ELEMENTS  (NUM_ELEMENTS),
      .NUM_DEVICES   (NUM_DEVICES),
      .ELEMENT_SHIFT (ELEMENT_SHIFT)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Build one emitted message; mark it local or link by device of source and destination.
   function automatic bcmr_rsp_type make_msg(bit [31:0] src, bit [31:0] dst, bit barrier,
                                             bit [31:0] id, bit [31:0] sender, bit parity);
      bcmr_rsp_type m;
      bit           link;
      link = (src % DEV_COUNT) != (dst % DEV_COUNT);
      m.out_dest_pe      = dst[PeBits-1:0];
      m.out_barrier      = barrier;
      m.out_id_or_count  = id;
      m.out_sender       = sender;
      m.out_round_parity = parity;
      m.via_link         = link;
      m.link_index       = link ? 2'((dst % DEV_COUNT) & 3) : 2'd0;
      m.last             = 1'b0;
      return m;
   endfunction

   // Work out the messages one accepted request causes and advance the counters.
   function automatic void route_request(bcmr_req_type r);
      bcmr_rsp_type     m;
      bit [31:0]        src;
      bit [31:0]        dst;
      bit [AddrW-1:0]   idx;
      int               j;
      src = 32'(r.source_pe);
      // Drop requests from elements that do not exist.
      if (src >= PE_COUNT) return;
      if (r.is_barrier) begin
         // Fan out to every element: report the pair's count, then clear it.
         for (j = 0; j < PE_COUNT; j++) begin
            idx = {src[PeBits-1:0], PeBits'(j)};
            m = make_msg(src, j, 1'b1, pair_count[idx], src << ELEMENT_SHIFT,
                         r.round_parity);
            m.last = (j == PE_COUNT - 1);
            expected_msgs.push_back(m);
            pair_count[idx] = '0;
         end
      end else begin
         dst = r.dest_id >> ELEMENT_SHIFT;
         // Drop ordinary messages to elements that do not exist.
         if (dst >= PE_COUNT) return;
         idx = {src[PeBits-1:0], dst[PeBits-1:0]};
         // Hold the counter at its maximum instead of wrapping.
         if (pair_count[idx] != 32'hFFFF_FFFF) pair_count[idx] = pair_count[idx] + 1;
         m = make_msg(src, dst, 1'b0, r.dest_id, r.sender_id, r.round_parity);
         m.last = 1'b1;
         expected_msgs.push_back(m);
      end
   endfunction

   task automatic queue_req(bit [3:0] src, bit barrier, bit [31:0] dest_id,
                            bit [31:0] sender, bit parity);
      bcmr_req_type r;
      r.source_pe    = src;
      r.is_barrier   = barrier;
      r.dest_id      = dest_id;
      r.sender_id    = sender;
      r.round_parity = parity;
      pending_reqs.push_back(r);
   endtask

   // Print one line per mismatch (up to a cap) and count every one.
   task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
   endtask

   task automatic check_msg(bcmr_rsp_type got);
      bcmr_rsp_type want;
      if (expected_msgs.size() == 0) begin
         flag_mismatch("unexpected message", got.out_id_or_count, 32'h0);
         return;
      end
      want = expected_msgs.pop_front();
      if (got.out_dest_pe !== want.out_dest_pe)
         flag_mismatch("out_dest_pe", 32'(got.out_dest_pe), 32'(want.out_dest_pe));
      if (got.out_barrier !== want.out_barrier)
         flag_mismatch("out_barrier", 32'(got.out_barrier), 32'(want.out_barrier));
      if (got.out_id_or_count !== want.out_id_or_count)
         flag_mismatch("out_id_or_count", got.out_id_or_count, want.out_id_or_count);
      if (got.out_sender !== want.out_sender)
         flag_mismatch("out_sender", got.out_sender, want.out_sender);
      if (got.out_round_parity !== want.out_round_parity)
         flag_mismatch("out_round_parity", 32'(got.out_round_parity),
                       32'(want.out_round_parity));
      if (got.via_link !== want.via_link)
         flag_mismatch("via_link", 32'(got.via_link), 32'(want.via_link));
      if (got.link_index !== want.link_index)
         flag_mismatch("link_index", 32'(got.link_index), 32'(want.link_index));
      if (got.last !== want.last)
         flag_mismatch("last", 32'(got.last), 32'(want.last));
   endtask

   // Driver: predict on every accepted request, then load the next one or go idle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            route_request(req_data);
            sent_count++;
         end
         // Only touch the channel when it is free after this edge.
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check every accepted message, stall the router at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_msg(rsp_data);
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int          i;
      bit [3:0]    src;
      bit [31:0]   pe;
      bit [31:0]   low_mask;
      bit          barrier;

      low_mask = (32'h1 << ELEMENT_SHIFT) - 1;

      // Barrier with every counter still zero.
      queue_req(4'd0, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0);
      // Ordinary extremes: element 0 local, element 15 over link 3.
      queue_req(4'd0, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0);
      queue_req(4'd0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      queue_req(4'd0, 1'b0, 32'h1234_5678, 32'hA5A5_5A5A, 1'b0);
      queue_req(4'd0, 1'b0, 32'h1FFF_FFFF, 32'h5A5A_A5A5, 1'b1);
      // Same device, different element: still local.
      queue_req(4'd0, 1'b0, 32'h4000_0001, 32'h8000_0000, 1'b0);
      // Barrier reports the counts, a second one sees them cleared.
      queue_req(4'd0, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b1);
      queue_req(4'd0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      // Highest source: local, link 0, local to element 3, local again, then a barrier.
      queue_req(4'd15, 1'b0, 32'hF000_0000, 32'h0000_0001, 1'b1);
      queue_req(4'd15, 1'b0, 32'h0FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      queue_req(4'd15, 1'b0, 32'h3000_0000, 32'hFFFF_FFFE, 1'b1);
      queue_req(4'd15, 1'b0, 32'hF000_0000, 32'h0000_0002, 1'b0);
      queue_req(4'd15, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b1);
      // Middle source over link 2; barrier ignores its id and sender fields.
      queue_req(4'd5, 1'b0, 32'h6000_0000, 32'h1111_1111, 1'b0);
      queue_req(4'd5, 1'b0, 32'h6ABC_DEF0, 32'h2222_2222, 1'b1);
      queue_req(4'd5, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);

      // Random traffic; favor a few elements so counters build up before barriers.
      for (i = 0; i < RANDOM_REQS; i++) begin
         src     = ($urandom_range(99) < 60) ? 4'($urandom_range(3)) : 4'($urandom);
         barrier = ($urandom_range(99) < 12);
         pe      = ($urandom_range(99) < 60) ? $urandom_range(3) : $urandom_range(15);
         queue_req(src, barrier, (pe << ELEMENT_SHIFT) | ($urandom & low_mask),
                   $urandom, 1'($urandom));
      end
      total_reqs = pending_reqs.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Swap the idle pattern after a third, then run at full rate.
      wait (sent_count >= total_reqs / 3);
      send_idle_pct  = 80;
      recv_stall_pct = 14;
      wait (sent_count >= 2 * total_reqs / 3);
      send_idle_pct  = 0;
      recv_stall_pct = 0;

      wait (sent_count == total_reqs);
      while (expected_msgs.size() != 0) @(posedge clock);
      // Hold a little longer so stray messages get caught.
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
